[rtl/catu_pkg.sv]
// shared constants, register indexes and the cordic arctangent table
`default_nettype none

package catu_pkg;

    // serial multiplier: signed multiplicand, unsigned multiplier scanned one bit a cycle
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 32;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // serial restoring divider: one quotient bit a cycle
    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // cordic
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CORDIC_CNT_W = $clog2(ATAN_ENTRIES);
    localparam int ANG_W        = 34;

    localparam logic signed [ANG_W-1:0] Q28_PI      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] Q28_HALF_PI = 34'sd421657428;
    localparam logic signed [ANG_W-1:0] Q28_TWO_PI  = 34'sd1686629713;
    localparam logic [MUL_B_W-1:0]      GAIN_Q30    = 32'd652032874;

    // configuration
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LIM_W      = 14;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ANGLE_GAIN     = 3'd0,
        REG_RATE_P_GAIN    = 3'd1,
        REG_RATE_I_GAIN    = 3'd2,
        REG_RATE_D_GAIN    = 3'd3,
        REG_SAMPLE_PERIOD  = 3'd4,
        REG_VEHICLE_WEIGHT = 3'd5,
        REG_THRUST_LIMIT   = 3'd6
    } reg_idx_t;

    localparam logic [CFG_DATA_W-1:0] RST_ANGLE_GAIN     = 16'd20480;
    localparam logic [CFG_DATA_W-1:0] RST_RATE_P_GAIN    = 16'd3277;
    localparam logic [CFG_DATA_W-1:0] RST_RATE_I_GAIN    = 16'd410;
    localparam logic [CFG_DATA_W-1:0] RST_RATE_D_GAIN    = 16'd82;
    localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_PERIOD  = 16'd164;
    localparam logic [CFG_DATA_W-1:0] RST_VEHICLE_WEIGHT = 16'd12306;
    localparam logic [LIM_W-1:0]      RST_THRUST_LIMIT   = 14'd10240;

    // pwm mapping constants
    localparam logic [MUL_B_W-1:0] PWM_SPAN  = 32'd1000;
    localparam logic [10:0]        PWM_BASE  = 11'd1000;
    localparam logic [MUL_B_W-1:0] SERVO_K   = 32'd800;
    localparam logic signed [63:0] SERVO_MID = 64'sd1500;
    localparam logic signed [63:0] SERVO_MAX = 64'sd4095;

    // atan(2^-i) in q.28
    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [CORDIC_CNT_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:    r = 34'sd210828714;
            5'd1:    r = 34'sd124459457;
            5'd2:    r = 34'sd65760959;
            5'd3:    r = 34'sd33381290;
            5'd4:    r = 34'sd16755422;
            5'd5:    r = 34'sd8385879;
            5'd6:    r = 34'sd4193963;
            5'd7:    r = 34'sd2097109;
            5'd8:    r = 34'sd1048571;
            5'd9:    r = 34'sd524287;
            5'd10:   r = 34'sd262144;
            5'd11:   r = 34'sd131072;
            5'd12:   r = 34'sd65536;
            5'd13:   r = 34'sd32768;
            5'd14:   r = 34'sd16384;
            5'd15:   r = 34'sd8192;
            5'd16:   r = 34'sd4096;
            5'd17:   r = 34'sd2048;
            5'd18:   r = 34'sd1024;
            5'd19:   r = 34'sd512;
            5'd20:   r = 34'sd256;
            5'd21:   r = 34'sd128;
            5'd22:   r = 34'sd64;
            5'd23:   r = 34'sd32;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/cascaded_attitude_thrust_allocator_unit.sv]
// cascaded pitch attitude controller with thrust allocation and pwm mapping
//
// one sample enters on the s_axis channel (pitch angle, pitch rate, target
// angle) and one result leaves on the m_axis channel (rear, front and servo
// pulse widths). gains, period, weight and thrust limit are written through
// the cfg port; the user must write them only while the block is idle, the
// block itself does not enforce this. a sequencer walks one sample through
// a shared bit-serial multiplier, a shared bit-serial divider and one cordic
// unit that does one rotation or vectoring step a cycle. a sample takes
// eleven products, three quotients and two 16-step cordic runs; a zero
// vector skips the vectoring run and its magnitude product. the next sample
// is taken once the current one has reached the output register.
// the result waits in the output register while m_axis_tready is low; the
// block accepts a new sample meanwhile but holds its finished result until
// the output register frees. reset sets the registers to their defaults and
// clears the integrator and the stored rate error.
`default_nettype none

module cascaded_attitude_thrust_allocator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pitch_angle[15:0], pitch_rate[35:16], target_angle[51:36]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // rear_pwm[10:0], front_pwm[21:11], servo_pwm[33:22]
    output logic      [39:0] m_axis_tdata,
    input  wire logic                              cfg_wen,
    input  wire logic [catu_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [catu_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [20:0] {
        ST_IDLE   = 21'h000001,
        ST_M_RDES = 21'h000002,
        ST_M_INT  = 21'h000004,
        ST_DIV_D  = 21'h000008,
        ST_M_P    = 21'h000010,
        ST_M_I    = 21'h000020,
        ST_M_D    = 21'h000040,
        ST_RED    = 21'h000080,
        ST_FLIP   = 21'h000100,
        ST_ROT    = 21'h000200,
        ST_M_S    = 21'h000400,
        ST_M_C    = 21'h000800,
        ST_VINIT  = 21'h001000,
        ST_VEC    = 21'h002000,
        ST_M_MAG  = 21'h004000,
        ST_M_SV   = 21'h008000,
        ST_M_TR   = 21'h010000,
        ST_DIV_R  = 21'h020000,
        ST_M_TF   = 21'h040000,
        ST_DIV_F  = 21'h080000,
        ST_OUT    = 21'h100000
    } state_t;

    localparam int AW = catu_pkg::ANG_W;

    // configuration
    logic [15:0] angle_gain_reg, rate_p_gain_reg, rate_i_gain_reg, rate_d_gain_reg;
    logic [15:0] sample_period_reg, vehicle_weight_reg;
    logic [catu_pkg::LIM_W-1:0] thrust_limit_reg;

    // controller state and sample
    state_t state_reg;
    logic   go_reg;
    logic signed [15:0] ang_reg, tgt_reg;
    logic signed [19:0] rate_reg;
    logic signed [23:0] err_reg, last_reg;
    logic signed [31:0] integ_reg;
    logic signed [41:0] deriv_reg;
    logic signed [63:0] sum_reg;
    logic [catu_pkg::LIM_W-1:0] tr_reg, tf_reg;
    logic signed [AW-1:0] x_reg, y_reg, z_reg;
    logic flip_reg;
    logic [catu_pkg::CORDIC_CNT_W-1:0] cnt_reg;
    logic signed [26:0] num_reg, den_reg;
    logic [23:0] pwm_num_reg;
    logic [11:0] servo_reg;
    logic [10:0] rear_reg, front_reg;

    // output register
    logic        out_valid_reg;
    logic [10:0] out_rear_reg, out_front_reg;
    logic [11:0] out_servo_reg;

    // shared units
    logic                                 mul_start, mul_done;
    logic signed [catu_pkg::MUL_A_W-1:0]  mul_a, mul_p;
    logic        [catu_pkg::MUL_B_W-1:0]  mul_b;
    logic                                 div_start, div_done;
    logic        [catu_pkg::DIV_N_W-1:0]  div_n, div_q;
    logic        [catu_pkg::DIV_D_W-1:0]  div_d;

    // datapath helpers
    logic [catu_pkg::LIM_W-1:0] lim;
    logic [15:0]                dt;
    logic signed [63:0]         lim_s;
    logic signed [AW-1:0]       ang_q28;
    logic signed [24:0]         rdiff;
    logic [24:0]                rdiff_mag;
    logic signed [63:0]         err_wide, integ_wide, den_wide, sv_wide;
    logic signed [AW-1:0]       xs, ys, at_i, x_step, y_step, z_step, a_wrap;
    logic                       step_up;
    logic                       cordic_last;
    logic                       accept;

    function automatic logic [catu_pkg::LIM_W-1:0] clamp_lim(
        input logic signed [63:0] v,
        input logic signed [63:0] l
    );
        logic [catu_pkg::LIM_W-1:0] r;
        if (v < 64'sd0)
        begin
            r = '0;
        end
        else if (v > l)
        begin
            r = l[catu_pkg::LIM_W-1:0];
        end
        else
        begin
            r = v[catu_pkg::LIM_W-1:0];
        end
        return r;
    endfunction

    assign lim       = (thrust_limit_reg == '0) ? catu_pkg::LIM_W'(1) : thrust_limit_reg;
    assign dt        = (sample_period_reg == '0) ? 16'd1 : sample_period_reg;
    assign lim_s     = $signed({50'b0, lim});
    assign ang_q28   = {{2{ang_reg[15]}}, ang_reg, 16'b0};
    assign rdiff     = 25'(err_reg) - 25'(last_reg);
    assign rdiff_mag = rdiff[24] ? 25'(-rdiff) : rdiff;
    assign err_wide  = (mul_p >>> 12) - 64'(rate_reg);
    assign integ_wide = 64'(integ_reg) + (mul_p >>> 12);
    assign den_wide  = $signed({40'b0, vehicle_weight_reg, 8'b0}) - (mul_p >>> 22);
    assign sv_wide   = catu_pkg::SERVO_MID + (mul_p >>> 28);
    assign accept    = s_axis_tvalid && s_axis_tready;

    // reduce the angle by one turn when past +-pi
    assign a_wrap = (ang_q28 > catu_pkg::Q28_PI)  ? ang_q28 - catu_pkg::Q28_TWO_PI :
                    (ang_q28 < -catu_pkg::Q28_PI) ? ang_q28 + catu_pkg::Q28_TWO_PI : ang_q28;

    // one cordic step; rotation and vectoring share the adders
    assign xs      = x_reg >>> cnt_reg;
    assign ys      = y_reg >>> cnt_reg;
    assign at_i    = catu_pkg::atan_q28(cnt_reg);
    assign step_up = (state_reg == ST_ROT) ? !z_reg[AW-1] : y_reg[AW-1];
    assign x_step  = step_up ? x_reg - ys : x_reg + ys;
    assign y_step  = step_up ? y_reg + xs : y_reg - xs;
    assign z_step  = step_up ? z_reg - at_i : z_reg + at_i;
    assign cordic_last = (cnt_reg == catu_pkg::CORDIC_CNT_W'(catu_pkg::CORDIC_ITERS - 1));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_M_RDES:
            begin
                mul_a = 64'(17'(tgt_reg) - 17'(ang_reg));
                mul_b = 32'(angle_gain_reg);
            end
            ST_M_INT:
            begin
                mul_a = 64'(err_reg);
                mul_b = 32'(sample_period_reg);
            end
            ST_M_P:
            begin
                mul_a = 64'(err_reg);
                mul_b = 32'(rate_p_gain_reg);
            end
            ST_M_I:
            begin
                mul_a = 64'(integ_reg);
                mul_b = 32'(rate_i_gain_reg);
            end
            ST_M_D:
            begin
                mul_a = 64'(deriv_reg);
                mul_b = 32'(rate_d_gain_reg);
            end
            ST_M_S:
            begin
                mul_a = 64'(y_reg);
                mul_b = 32'(tr_reg);
            end
            ST_M_C:
            begin
                mul_a = 64'(x_reg);
                mul_b = 32'(tr_reg);
            end
            ST_M_MAG:
            begin
                mul_a = 64'(x_reg);
                mul_b = catu_pkg::GAIN_Q30;
            end
            ST_M_SV:
            begin
                mul_a = 64'(z_reg) - 64'(ang_q28);
                mul_b = catu_pkg::SERVO_K;
            end
            ST_M_TR:
            begin
                mul_a = $signed({50'b0, tr_reg});
                mul_b = catu_pkg::PWM_SPAN;
            end
            ST_M_TF:
            begin
                mul_a = $signed({50'b0, tf_reg});
                mul_b = catu_pkg::PWM_SPAN;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_n = '0;
        div_d = lim_s[15:0];
        case (state_reg)
            ST_DIV_D:
            begin
                div_n = {7'b0, rdiff_mag, 16'b0};
                div_d = dt;
            end
            ST_DIV_R, ST_DIV_F:
            begin
                div_n = {24'b0, pwm_num_reg};
                div_d = lim_s[15:0];
            end
            default:
            begin
                div_n = '0;
                div_d = lim_s[15:0];
            end
        endcase
    end

    assign mul_start = go_reg && (state_reg != ST_DIV_D) && (state_reg != ST_DIV_R)
                              && (state_reg != ST_DIV_F);
    assign div_start = go_reg && ((state_reg == ST_DIV_D) || (state_reg == ST_DIV_R)
                              || (state_reg == ST_DIV_F));

    catu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    catu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .done  (div_done),
        .q     (div_q)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_gain_reg     <= catu_pkg::RST_ANGLE_GAIN;
            rate_p_gain_reg    <= catu_pkg::RST_RATE_P_GAIN;
            rate_i_gain_reg    <= catu_pkg::RST_RATE_I_GAIN;
            rate_d_gain_reg    <= catu_pkg::RST_RATE_D_GAIN;
            sample_period_reg  <= catu_pkg::RST_SAMPLE_PERIOD;
            vehicle_weight_reg <= catu_pkg::RST_VEHICLE_WEIGHT;
            thrust_limit_reg   <= catu_pkg::RST_THRUST_LIMIT;
        end
        else if (cfg_wen)
        begin
            case (catu_pkg::reg_idx_t'(cfg_addr))
                catu_pkg::REG_ANGLE_GAIN:     angle_gain_reg     <= cfg_data;
                catu_pkg::REG_RATE_P_GAIN:    rate_p_gain_reg    <= cfg_data;
                catu_pkg::REG_RATE_I_GAIN:    rate_i_gain_reg    <= cfg_data;
                catu_pkg::REG_RATE_D_GAIN:    rate_d_gain_reg    <= cfg_data;
                catu_pkg::REG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data;
                catu_pkg::REG_VEHICLE_WEIGHT: vehicle_weight_reg <= cfg_data;
                catu_pkg::REG_THRUST_LIMIT:   thrust_limit_reg   <= cfg_data[catu_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            integ_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            ang_reg <= '0; tgt_reg <= '0; rate_reg <= '0;
            err_reg <= '0; deriv_reg <= '0; sum_reg <= '0;
            tr_reg <= '0; tf_reg <= '0;
            x_reg <= '0; y_reg <= '0; z_reg <= '0;
            flip_reg <= 1'b0; cnt_reg <= '0;
            num_reg <= '0; den_reg <= '0; pwm_num_reg <= '0;
            servo_reg <= '0; rear_reg <= '0; front_reg <= '0;
            out_rear_reg <= '0; out_front_reg <= '0; out_servo_reg <= '0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ang_reg   <= s_axis_tdata[15:0];
                        rate_reg  <= s_axis_tdata[35:16];
                        tgt_reg   <= s_axis_tdata[51:36];
                        state_reg <= ST_M_RDES;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_RDES:
                begin
                    if (mul_done)
                    begin
                        if (err_wide > 64'sd8388607)
                        begin
                            err_reg <= 24'sh7FFFFF;
                        end
                        else if (err_wide < -64'sd8388608)
                        begin
                            err_reg <= 24'sh800000;
                        end
                        else
                        begin
                            err_reg <= err_wide[23:0];
                        end
                        state_reg <= ST_M_INT;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_INT:
                begin
                    if (mul_done)
                    begin
                        if (integ_wide > 64'sd2147483647)
                        begin
                            integ_reg <= 32'sh7FFFFFFF;
                        end
                        else if (integ_wide < -64'sd2147483648)
                        begin
                            integ_reg <= 32'sh80000000;
                        end
                        else
                        begin
                            integ_reg <= integ_wide[31:0];
                        end
                        state_reg <= ST_DIV_D;
                        go_reg    <= 1'b1;
                    end
                end
                ST_DIV_D:
                begin
                    if (div_done)
                    begin
                        // quotient of magnitudes, sign restored for truncation toward zero
                        deriv_reg <= rdiff[24] ? -$signed(div_q[41:0]) : $signed(div_q[41:0]);
                        last_reg  <= err_reg;
                        state_reg <= ST_M_P;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_P:
                begin
                    if (mul_done)
                    begin
                        sum_reg   <= mul_p <<< 4;
                        state_reg <= ST_M_I;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_I:
                begin
                    if (mul_done)
                    begin
                        sum_reg   <= sum_reg + mul_p;
                        state_reg <= ST_M_D;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_D:
                begin
                    if (mul_done)
                    begin
                        sum_reg   <= sum_reg + (mul_p <<< 4);
                        state_reg <= ST_RED;
                    end
                end
                ST_RED:
                begin
                    tr_reg    <= clamp_lim(sum_reg >>> 20, lim_s);
                    z_reg     <= a_wrap;
                    state_reg <= ST_FLIP;
                end
                ST_FLIP:
                begin
                    // fold into +-pi/2 and negate the result later
                    if (z_reg > catu_pkg::Q28_HALF_PI)
                    begin
                        z_reg    <= z_reg - catu_pkg::Q28_PI;
                        flip_reg <= 1'b1;
                    end
                    else if (z_reg < -catu_pkg::Q28_HALF_PI)
                    begin
                        z_reg    <= z_reg + catu_pkg::Q28_PI;
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        flip_reg <= 1'b0;
                    end
                    x_reg     <= AW'(signed'({1'b0, catu_pkg::GAIN_Q30}));
                    y_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    z_reg   <= z_step;
                    if (cordic_last)
                    begin
                        x_reg     <= flip_reg ? -x_step : x_step;
                        y_reg     <= flip_reg ? -y_step : y_step;
                        state_reg <= ST_M_S;
                        go_reg    <= 1'b1;
                    end
                    else
                    begin
                        x_reg <= x_step;
                        y_reg <= y_step;
                    end
                end
                ST_M_S:
                begin
                    if (mul_done)
                    begin
                        num_reg   <= 27'(-(mul_p >>> 22));
                        state_reg <= ST_M_C;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_C:
                begin
                    if (mul_done)
                    begin
                        den_reg   <= den_wide[26:0];
                        state_reg <= ST_VINIT;
                    end
                end
                ST_VINIT:
                begin
                    cnt_reg <= '0;
                    if (num_reg == '0 && den_reg == '0)
                    begin
                        // zero vector: angle zero, no front thrust
                        z_reg     <= '0;
                        tf_reg    <= '0;
                        state_reg <= ST_M_SV;
                        go_reg    <= 1'b1;
                    end
                    else
                    begin
                        if (den_reg[26])
                        begin
                            x_reg <= -AW'(den_reg);
                            y_reg <= -AW'(num_reg);
                            z_reg <= num_reg[26] ? -catu_pkg::Q28_PI : catu_pkg::Q28_PI;
                        end
                        else
                        begin
                            x_reg <= AW'(den_reg);
                            y_reg <= AW'(num_reg);
                            z_reg <= '0;
                        end
                        state_reg <= ST_VEC;
                    end
                end
                ST_VEC:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    x_reg   <= x_step;
                    y_reg   <= y_step;
                    z_reg   <= z_step;
                    if (cordic_last)
                    begin
                        state_reg <= ST_M_MAG;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_MAG:
                begin
                    if (mul_done)
                    begin
                        tf_reg    <= (den_reg == '0) ? lim
                                                     : clamp_lim((mul_p >>> 30) >>> 8, lim_s);
                        state_reg <= ST_M_SV;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_SV:
                begin
                    if (mul_done)
                    begin
                        if (sv_wide < 64'sd0)
                        begin
                            servo_reg <= '0;
                        end
                        else if (sv_wide > catu_pkg::SERVO_MAX)
                        begin
                            servo_reg <= 12'hFFF;
                        end
                        else
                        begin
                            servo_reg <= sv_wide[11:0];
                        end
                        state_reg <= ST_M_TR;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_TR:
                begin
                    if (mul_done)
                    begin
                        pwm_num_reg <= mul_p[23:0];
                        state_reg   <= ST_DIV_R;
                        go_reg      <= 1'b1;
                    end
                end
                ST_DIV_R:
                begin
                    if (div_done)
                    begin
                        rear_reg  <= catu_pkg::PWM_BASE + div_q[10:0];
                        state_reg <= ST_M_TF;
                        go_reg    <= 1'b1;
                    end
                end
                ST_M_TF:
                begin
                    if (mul_done)
                    begin
                        pwm_num_reg <= mul_p[23:0];
                        state_reg   <= ST_DIV_F;
                        go_reg      <= 1'b1;
                    end
                end
                ST_DIV_F:
                begin
                    if (div_done)
                    begin
                        front_reg <= catu_pkg::PWM_BASE + div_q[10:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // hand over once the output register is free
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_rear_reg  <= rear_reg;
                        out_front_reg <= front_reg;
                        out_servo_reg <= servo_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_servo_reg, out_front_reg, out_rear_reg};

endmodule

`default_nettype wire

[rtl/catu_mul.sv]
// bit-serial shift-add multiplier, signed multiplicand times unsigned multiplier
`default_nettype none

module catu_mul (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic signed [catu_pkg::MUL_A_W-1:0]  a,
    input  wire logic        [catu_pkg::MUL_B_W-1:0]  b,
    output logic                                      done,
    output logic signed      [catu_pkg::MUL_A_W-1:0]  p
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [catu_pkg::MUL_CNT_W-1:0]       cnt_reg;
    logic signed [catu_pkg::MUL_A_W-1:0]  a_reg;
    logic [catu_pkg::MUL_B_W-1:0]         b_reg;
    logic signed [catu_pkg::MUL_A_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == catu_pkg::MUL_CNT_W'(catu_pkg::MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

[rtl/catu_div.sv]
// bit-serial restoring divider, unsigned, quotient truncated
`default_nettype none

module catu_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [catu_pkg::DIV_N_W-1:0]  n,
    input  wire logic [catu_pkg::DIV_D_W-1:0]  d,
    output logic                               done,
    output logic      [catu_pkg::DIV_N_W-1:0]  q
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [catu_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [catu_pkg::DIV_N_W-1:0]      n_reg;
    logic [catu_pkg::DIV_D_W-1:0]      d_reg;
    logic [catu_pkg::DIV_D_W-1:0]      rem_reg;
    logic [catu_pkg::DIV_N_W-1:0]      q_reg;
    logic [catu_pkg::DIV_D_W:0]        trial;
    logic                              fits;

    assign trial = {rem_reg, n_reg[catu_pkg::DIV_N_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == catu_pkg::DIV_CNT_W'(catu_pkg::DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= n;
            d_reg   <= d;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? catu_pkg::DIV_D_W'(trial - {1'b0, d_reg})
                            : trial[catu_pkg::DIV_D_W-1:0];
            q_reg   <= {q_reg[catu_pkg::DIV_N_W-2:0], fits};
            n_reg   <= n_reg << 1;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

[verif/cascaded_attitude_thrust_allocator_unit_checker.sv]
// checker: predicts each pulse-width result from the accepted requests and compares
module cascaded_attitude_thrust_allocator_unit_checker
    import catu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    // pitch_angle[15:0], pitch_rate[35:16], target_angle[51:36]
    input  wire logic [55:0]           s_axis_tdata,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // rear_pwm[10:0], front_pwm[21:11], servo_pwm[33:22]
    input  wire logic [39:0]           m_axis_tdata,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);

    localparam longint ATAN_TAB [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    logic [15:0] angle_gain, rate_p_gain, rate_i_gain, rate_d_gain;
    logic [15:0] sample_period, vehicle_weight;
    logic [13:0] thrust_limit;
    longint      integ_acc;
    longint      prev_rate_err;
    logic [33:0] pwm_queue [$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [33:0] pulse_widths(input logic [55:0] req);
        longint ang, rate, tgt, dt, lim, kg, kp, ki, kd, prd, wt;
        longint rdes, err, deriv, sum, tr, tf, c, s, num, den, at, mag, alpha, sv;
        longint x, y, z, a, t, rear, front;
        logic   flip;
        ang  = longint'($signed(req[15:0]));
        rate = longint'($signed(req[35:16]));
        tgt  = longint'($signed(req[51:36]));
        kg   = angle_gain;
        kp   = rate_p_gain;
        ki   = rate_i_gain;
        kd   = rate_d_gain;
        prd  = sample_period;
        wt   = vehicle_weight;
        dt   = (prd != 0) ? prd : 1;
        lim  = (thrust_limit != 0) ? longint'(thrust_limit) : 1;

        rdes = (kg * (tgt - ang)) >>> 12;
        err = clip(rdes - rate, -64'sd8388608, 64'sd8388607);
        integ_acc = clip(integ_acc + ((err * prd) >>> 12), -64'sd2147483648, 64'sd2147483647);
        deriv = ((err - prev_rate_err) * 65536) / dt;
        sum = 16 * (kp * err) + ki * integ_acc + 16 * (kd * deriv);
        prev_rate_err = err;
        tr = clip(sum >>> 20, 0, lim);

        // rotation cordic on the measured angle, folded into half a turn
        a = ang * 65536;
        while (a > longint'(Q28_PI))
            a = a - longint'(Q28_TWO_PI);
        while (a < -longint'(Q28_PI))
            a = a + longint'(Q28_TWO_PI);
        flip = 1'b0;
        if (a > longint'(Q28_HALF_PI))
        begin
            a = a - longint'(Q28_PI);
            flip = 1'b1;
        end
        else if (a < -longint'(Q28_HALF_PI))
        begin
            a = a + longint'(Q28_PI);
            flip = 1'b1;
        end
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            if (a >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                a = a - ATAN_TAB[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                a = a + ATAN_TAB[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;

        num = -((tr * s) >>> 22);
        den = wt * 256 - ((tr * c) >>> 22);
        if (num == 0 && den == 0)
        begin
            at = 0;
            tf = 0;
        end
        else
        begin
            x = den;
            y = num;
            z = 0;
            // left half plane: turn by half a turn first
            if (den < 0)
            begin
                x = -den;
                y = -num;
                z = (num >= 0) ? longint'(Q28_PI) : -longint'(Q28_PI);
            end
            for (int i = 0; i < CORDIC_ITERS; i++)
            begin
                if (y >= 0)
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + ATAN_TAB[i];
                end
                else
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - ATAN_TAB[i];
                end
                x = t;
            end
            at = z;
            mag = (x * longint'(GAIN_Q30)) >>> 30;
            tf = (den == 0) ? lim : clip(mag >>> 8, 0, lim);
        end
        alpha = at - ang * 65536;
        sv = clip(1500 + ((alpha * 800) >>> 28), 0, 4095);
        rear = 1000 + (tr * 1000) / lim;
        front = 1000 + (tf * 1000) / lim;
        return {sv[11:0], front[10:0], rear[10:0]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [33:0] exp_pwm;
        if (!rst_n)
        begin
            angle_gain = RST_ANGLE_GAIN;
            rate_p_gain = RST_RATE_P_GAIN;
            rate_i_gain = RST_RATE_I_GAIN;
            rate_d_gain = RST_RATE_D_GAIN;
            sample_period = RST_SAMPLE_PERIOD;
            vehicle_weight = RST_VEHICLE_WEIGHT;
            thrust_limit = RST_THRUST_LIMIT;
            integ_acc = 0;
            prev_rate_err = 0;
            pwm_queue.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_addr)
                    REG_ANGLE_GAIN:     angle_gain = cfg_data;
                    REG_RATE_P_GAIN:    rate_p_gain = cfg_data;
                    REG_RATE_I_GAIN:    rate_i_gain = cfg_data;
                    REG_RATE_D_GAIN:    rate_d_gain = cfg_data;
                    REG_SAMPLE_PERIOD:  sample_period = cfg_data;
                    REG_VEHICLE_WEIGHT: vehicle_weight = cfg_data;
                    REG_THRUST_LIMIT:   thrust_limit = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                pwm_queue.push_back(pulse_widths(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pwm_queue.size() == 0)
                begin
                    $error("unexpected result %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_pwm = pwm_queue.pop_front();
                    if (m_axis_tdata[10:0] !== exp_pwm[10:0])
                    begin
                        $error("rear_pwm expected %0d actual %0d", exp_pwm[10:0],
                               m_axis_tdata[10:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[21:11] !== exp_pwm[21:11])
                    begin
                        $error("front_pwm expected %0d actual %0d", exp_pwm[21:11],
                               m_axis_tdata[21:11]);
                        fail_count++;
                    end
                    if (m_axis_tdata[33:22] !== exp_pwm[33:22])
                    begin
                        $error("servo_pwm expected %0d actual %0d", exp_pwm[33:22],
                               m_axis_tdata[33:22]);
                        fail_count++;
                    end
                end
            end
            pending = pwm_queue.size();
        end
    end

endmodule

[verif/cascaded_attitude_thrust_allocator_unit_test.sv]
// testbench top: clock, reset, samples, register settings and the verdict
module cascaded_attitude_thrust_allocator_unit_test;
    import catu_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 800;
    localparam logic [15:0] HALF_PI_Q12 = 16'd6434;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [39:0]           m_axis_tdata;
    logic                  cfg_wen;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    stall_cycles;
    int                    ready_hold;
    logic                  quiet;

    cascaded_attitude_thrust_allocator_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    cascaded_attitude_thrust_allocator_unit_checker pwm_check (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side stalls in random bursts
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
                ready_hold <= $urandom_range(1, 9);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("cascaded_attitude_thrust_allocator_unit regression: fail");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] ang, input logic [19:0] rate,
                               input logic [15:0] tgt);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, tgt, rate, ang};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // only between phases: drain every request, then let the pipeline settle
    task automatic write_regs(input logic [15:0] kg, input logic [15:0] kp,
                              input logic [15:0] ki, input logic [15:0] kd,
                              input logic [15:0] prd, input logic [15:0] wt,
                              input logic [15:0] lim);
        logic [15:0] vals [7];
        vals = '{kg, kp, ki, kd, prd, wt, lim};
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 7; i++)
        begin
            cfg_wen <= 1'b1;
            cfg_addr <= i[CFG_ADDR_W-1:0];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        // spare index must be ignored
        cfg_addr <= REG_SPARE;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic random_sample(input logic near_vertical);
        logic [15:0] ang, tgt;
        logic [19:0] rate;
        case ($urandom_range(0, 9))
            0:
            begin
                ang = $urandom;
                rate = $urandom;
                tgt = $urandom;
            end
            1:
            begin
                ang = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                rate = $urandom_range(0, 1) ? 20'h7ffff : 20'h80000;
                tgt = $urandom;
            end
            default:
            begin
                ang = 16'($urandom_range(0, 2 * 6434)) - 16'd6434;
                rate = 20'($urandom_range(0, 8192)) - 20'd4096;
                tgt = ang + 16'($urandom_range(0, 2048)) - 16'd1024;
            end
        endcase
        if (near_vertical && $urandom_range(0, 1))
            ang = $urandom_range(0, 1) ? HALF_PI_Q12 : -HALF_PI_Q12;
        send_sample(ang, rate, tgt);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_wen = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        quiet = 1'b0;
        ready_hold = 0;
        stall_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, then small, vertical and near-pi angles, at reset settings
        send_sample(16'h0000, 20'h00000, 16'h0000);
        send_sample(16'h7fff, 20'h7ffff, 16'h8000);
        send_sample(16'h8000, 20'h80000, 16'h7fff);
        send_sample(16'hffff, 20'hfffff, 16'hffff);
        send_sample(16'h0000, 20'h80000, 16'h7fff);
        send_sample(16'h0000, 20'h7ffff, 16'h8000);
        send_sample(16'd1024, 20'd0, 16'd0);
        send_sample(-16'd1024, 20'd0, 16'd0);
        send_sample(HALF_PI_Q12, 20'd100, HALF_PI_Q12 + 16'd800);
        send_sample(16'd12868, 20'd0, 16'd12000);
        send_sample(-16'd12868, 20'd0, -16'd12000);

        // zero weight: zero vector, negative den and zero cosine
        write_regs(16'd20480, 16'd3277, 16'd410, 16'd82, 16'd164, 16'd0, 16'd10240);
        send_sample(16'd0, 20'd0, 16'd0);
        send_sample(16'd500, 20'd0, 16'd2000);
        send_sample(HALF_PI_Q12, 20'd0, HALF_PI_Q12 + 16'd2000);
        send_sample(-HALF_PI_Q12, 20'd0, -HALF_PI_Q12 + 16'd2000);
        send_sample(-16'd500, 20'h80000, 16'd0);

        // register extremes: zero period and zero limit, then all ones
        write_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'd100, 20'd5, 16'd200);
        send_sample(16'h8000, 20'h7ffff, 16'h7fff);
        write_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h3fff);
        send_sample(16'h7fff, 20'h80000, 16'h8000);
        send_sample(16'h8000, 20'h7ffff, 16'h7fff);
        send_sample(16'd0, 20'd1, 16'd0);

        // random phases
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: write_regs(16'd20480, 16'd3277, 16'd410, 16'd82, 16'd164,
                              16'd12306, 16'd10240);
                1: write_regs(16'd20480, 16'd3277, 16'd410, 16'd82, 16'd164,
                              16'd0, 16'd10240);
                2: write_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd1,
                              16'hffff, 16'h3fff);
                3: write_regs(16'd4096, 16'd4096, 16'd0, 16'd0, 16'd1, 16'd256, 16'd1);
                default: write_regs($urandom, $urandom_range(0, 16384),
                                    $urandom_range(0, 4096), $urandom_range(0, 1024),
                                    $urandom_range(1, 65535), $urandom_range(0, 20000),
                                    $urandom_range(1, 16383));
            endcase
            if (ph == 8)
                quiet = 1'b1;
            for (int n = 0; n < 30; n++)
                random_sample(ph == 1);
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("cascaded_attitude_thrust_allocator_unit regression: pass");
        else
            $display("cascaded_attitude_thrust_allocator_unit regression: fail");
        $finish;
    end

endmodule
